[rtl/core/tcgw_pkg.sv]
`timescale 1ns / 1ps

package tcgw_pkg;

   // glyph cell geometry
   localparam int unsigned GLYPH_ROWS = 16;
   localparam int unsigned GLYPH_COLS = 8;

   // field widths
   localparam int unsigned OFFSET_W = 26;
   localparam int unsigned MUL_B_W  = 13;
   localparam int unsigned POS_W    = 9;
   localparam int unsigned DIM_W    = 12;
   localparam int unsigned PB_W     = 3;
   localparam int unsigned COLOR_W  = 24;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [7:0]       NEWLINE_CODE = 8'd10;
   localparam logic [POS_W-1:0] LINE_MAX     = 9'd511;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_BYTES   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR      = 2'd3;

   // operands of the shared multiply-add unit: a * b + c
   typedef struct packed {
      logic [OFFSET_W-1:0] a;
      logic [MUL_B_W-1:0]  b;
      logic [OFFSET_W-1:0] c;
   } mac_op_type;

endpackage

[rtl/core/tcgw_mac.sv]
`timescale 1ns / 1ps

module tcgw_mac
   import tcgw_pkg::*;
(
   input  mac_op_type          op,
   output logic [OFFSET_W-1:0] result
);

   logic [OFFSET_W+MUL_B_W-1:0] prod;

   // product and sum taken modulo the offset range
   always_comb begin
      prod   = op.a * {{OFFSET_W{1'b0}}, op.b};
      result = prod[OFFSET_W-1:0] + op.c;
   end

endmodule

[rtl/core/text_console_glyph_writer_core.sv]
`timescale 1ns / 1ps
// A taken character passes through ST_LIN, ST_BASE and ST_STEP to ST_EMIT, which
// loads one row write per cycle while rsp_tready is high, 16 in all. Input is
// taken only in idle; a newline does not leave idle, and a suppressed character
// goes straight to ST_EMIT. One shared multiply-add unit forms the base offset
// and row stride in three steps and then steps through the rows.
// Reset (synchronous): cursor to column 0, line 0, registers to 800/600/4/white.

module text_console_glyph_writer_core
   import tcgw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   // configuration write port
   input  logic           csr_wr_en,
   input  logic [1:0]     csr_index,
   input  logic [23:0]    csr_wr_data,
   // character input
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [135:0]   req_tdata,   // char_code, glyph_upper, glyph_lower
   // row write output
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [63:0]    rsp_tdata,   // byte_offset, pixel_mask, fill_color, zero pad
   output logic           rsp_tlast,
   output logic           rsp_tuser    // off_screen
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIN,
      ST_BASE,
      ST_STEP,
      ST_EMIT
   } state_type;

   // configuration
   logic [DIM_W-1:0]   width_ff,  width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [PB_W-1:0]    pb_ff,     pb_in;
   logic [COLOR_W-1:0] color_ff,  color_in;

   // cursor and work registers
   state_type           state_ff, state_in;
   logic [POS_W-1:0]    col_ff,  col_in;
   logic [POS_W-1:0]    line_ff, line_in;
   logic [POS_W-1:0]    wcol_ff, wcol_in;
   logic [POS_W-1:0]    wline_ff, wline_in;
   logic                offs_ff, offs_in;
   logic [127:0]        glyph_ff, glyph_in;
   logic [OFFSET_W-1:0] off_ff,  off_in;
   logic [OFFSET_W-1:0] step_ff, step_in;
   logic [3:0]          row_ff,  row_in;

   // output register
   logic                out_valid_ff, out_valid_in;
   logic [OFFSET_W-1:0] out_off_ff,  out_off_in;
   logic [7:0]          out_mask_ff, out_mask_in;
   logic [COLOR_W-1:0]  out_color_ff, out_color_in;
   logic                out_last_ff, out_last_in;
   logic                out_user_ff, out_user_in;

   // shared multiply-add unit
   mac_op_type          mac_op;
   logic [OFFSET_W-1:0] mac_res;

   tcgw_mac u_mac (
      .op     (mac_op),
      .result (mac_res)
   );

   // cursor arithmetic at the input transfer
   logic [POS_W-1:0] cols;
   logic [POS_W-1:0] lines;
   logic             stale;
   logic [POS_W-1:0] eff_col;
   logic [POS_W-1:0] eff_line;
   logic [POS_W:0]   col_inc;
   logic             wrap;
   logic             req_fire;
   logic             slot_free;
   logic [7:0]       char_code;

   always_comb begin
      char_code = req_tdata[7:0];
      cols      = (width_ff[DIM_W-1:3] == '0) ? POS_W'(1) : width_ff[DIM_W-1:3];
      lines     = {1'b0, height_ff[DIM_W-1:4]};
      stale     = (col_ff >= cols);
      eff_col   = stale ? '0 : col_ff;
      eff_line  = (stale && line_ff != LINE_MAX) ? line_ff + POS_W'(1) : line_ff;
      col_inc   = {1'b0, eff_col} + (POS_W+1)'(1);
      wrap      = (col_inc >= {1'b0, cols});
      req_fire  = req_tvalid && req_tready;
      slot_free = !out_valid_ff || rsp_tready;
   end

   // shared unit operand select
   always_comb begin
      mac_op = '{a: '0, b: '0, c: '0};
      case (state_ff)
         ST_LIN: begin
            mac_op.a = OFFSET_W'(width_ff);
            mac_op.b = {wline_ff, 4'd0};
            mac_op.c = OFFSET_W'({wcol_ff, 3'd0});
         end
         ST_BASE: begin
            mac_op.a = off_ff;
            mac_op.b = MUL_B_W'(pb_ff);
         end
         ST_STEP: begin
            mac_op.a = OFFSET_W'(width_ff);
            mac_op.b = MUL_B_W'(pb_ff);
         end
         ST_EMIT: begin
            mac_op.a = step_ff;
            mac_op.b = MUL_B_W'(1);
            mac_op.c = off_ff;
         end
         default: begin
            mac_op = '{a: '0, b: '0, c: '0};
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      pb_in        = pb_ff;
      color_in     = color_ff;
      state_in     = state_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      wcol_in      = wcol_ff;
      wline_in     = wline_ff;
      offs_in      = offs_ff;
      glyph_in     = glyph_ff;
      off_in       = off_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      out_valid_in = out_valid_ff;
      out_off_in   = out_off_ff;
      out_mask_in  = out_mask_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      out_user_in  = out_user_ff;

      // configuration writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_wr_data[DIM_W-1:0];
            CSR_SCREEN_HEIGHT: height_in = csr_wr_data[DIM_W-1:0];
            CSR_PIXEL_BYTES:   pb_in     = csr_wr_data[PB_W-1:0];
            CSR_FG_COLOR:      color_in  = csr_wr_data[COLOR_W-1:0];
            default:           width_in  = width_ff;
         endcase
      end

      // output slot drained
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (char_code == NEWLINE_CODE) begin
                  col_in  = '0;
                  line_in = (line_ff != LINE_MAX) ? line_ff + POS_W'(1) : line_ff;
               end else begin
                  wcol_in  = eff_col;
                  wline_in = eff_line;
                  offs_in  = (eff_line >= lines);
                  glyph_in = {req_tdata[71:8], req_tdata[135:72]};
                  row_in   = '0;
                  if (wrap) begin
                     col_in  = '0;
                     line_in = (eff_line != LINE_MAX) ? eff_line + POS_W'(1) : eff_line;
                  end else begin
                     col_in  = col_inc[POS_W-1:0];
                     line_in = eff_line;
                  end
                  state_in = (eff_line >= lines) ? ST_EMIT : ST_LIN;
               end
            end
         end
         ST_LIN: begin
            off_in   = mac_res;
            state_in = ST_BASE;
         end
         ST_BASE: begin
            off_in   = mac_res;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            step_in  = mac_res;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               if (offs_ff) begin
                  out_off_in   = '0;
                  out_mask_in  = '0;
                  out_color_in = '0;
                  out_last_in  = 1'b1;
                  out_user_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  out_off_in   = off_ff;
                  out_mask_in  = glyph_ff[127:120];
                  out_color_in = color_ff;
                  out_last_in  = (row_ff == 4'(GLYPH_ROWS - 1));
                  out_user_in  = 1'b0;
                  off_in       = mac_res;
                  glyph_in     = {glyph_ff[119:0], 8'd0};
                  row_in       = row_ff + 4'd1;
                  if (row_ff == 4'(GLYPH_ROWS - 1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= 12'd800;
         height_ff    <= 12'd600;
         pb_ff        <= 3'd4;
         color_ff     <= 24'hFFFFFF;
         col_ff       <= '0;
         line_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         pb_ff        <= pb_in;
         color_ff     <= color_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         out_valid_ff <= out_valid_in;
      end
      wcol_ff      <= wcol_in;
      wline_ff     <= wline_in;
      offs_ff      <= offs_in;
      glyph_ff     <= glyph_in;
      off_ff       <= off_in;
      step_ff      <= step_in;
      row_ff       <= row_in;
      out_off_ff   <= out_off_in;
      out_mask_ff  <= out_mask_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
      out_user_ff  <= out_user_in;
   end

   // ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_color_ff, out_mask_ff, out_off_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

   // a suppressed character is a single transfer of its own
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == 64'd0))
      else $error("suppressed result not a lone zero transfer");

   // a printable character holds off the input side
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata[7:0] != NEWLINE_CODE) |=> !req_tready)
      else $error("input taken while a character is in progress");

   // rows are only produced while the sequencer is emitting
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) && state_ff == ST_LIN |=> !rsp_tvalid)
      else $error("row write appeared during offset setup");

endmodule

[bench/tb_text_console_glyph_writer_core.sv]
`timescale 1ns / 1ps

module tb_text_console_glyph_writer_core;
   import tcgw_pkg::*;

   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 32;

   // one expected row write
   typedef struct {
      logic [OFFSET_W-1:0] byte_offset;
      logic [7:0]          pixel_mask;
      logic [COLOR_W-1:0]  fill_color;
      logic                last;
      logic                off_screen;
   } glyph_row_type;

   // cursor tracking, row write prediction and comparison
   class glyph_row_book_type;
      logic [DIM_W-1:0]   screen_width;
      logic [DIM_W-1:0]   screen_height;
      logic [PB_W-1:0]    pixel_bytes;
      logic [COLOR_W-1:0] fg_color;
      logic [POS_W-1:0]   cursor_column;
      logic [POS_W-1:0]   cursor_line;
      glyph_row_type      pending[$];
      int unsigned        failures;
      int unsigned        rows_checked;
      int unsigned        glyphs_drawn;
      int unsigned        glyphs_hidden;
      int unsigned        newlines;
      int unsigned        reg_writes;

      function new();
         screen_width  = 12'd800;
         screen_height = 12'd600;
         pixel_bytes   = 3'd4;
         fg_color      = 24'hFFFFFF;
         cursor_column = '0;
         cursor_line   = '0;
         failures      = 0;
         rows_checked  = 0;
         glyphs_drawn  = 0;
         glyphs_hidden = 0;
         newlines      = 0;
         reg_writes    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [23:0] value);
         case (idx)
            CSR_SCREEN_WIDTH:  screen_width  = value[DIM_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height = value[DIM_W-1:0];
            CSR_PIXEL_BYTES:   pixel_bytes   = value[PB_W-1:0];
            CSR_FG_COLOR:      fg_color      = value[COLOR_W-1:0];
            default: ;
         endcase
         reg_writes++;
      endfunction

      // column 0 of the next line, line saturates
      function void line_feed();
         cursor_column = '0;
         if (cursor_line < LINE_MAX)
            cursor_line = cursor_line + 1'b1;
      endfunction

      function void note_char(logic [7:0] code, logic [63:0] upper, logic [63:0] lower);
         int unsigned     columns;
         int unsigned     lines;
         longint unsigned pos_x;
         longint unsigned pos_y;
         longint unsigned offset;
         logic [63:0]     rows;
         glyph_row_type   row;
         columns = screen_width / GLYPH_COLS;
         if (columns == 0)
            columns = 1;
         lines = screen_height / GLYPH_ROWS;
         if (code == NEWLINE_CODE) begin
            line_feed();
            newlines++;
            return;
         end
         // width shrank under the cursor
         if (cursor_column >= columns)
            line_feed();
         if (cursor_line >= lines) begin
            row.byte_offset = '0;
            row.pixel_mask  = '0;
            row.fill_color  = '0;
            row.last        = 1'b1;
            row.off_screen  = 1'b1;
            pending.push_back(row);
            glyphs_hidden++;
         end else begin
            pos_x = longint'(cursor_column) * GLYPH_COLS;
            for (int r = 0; r < GLYPH_ROWS; r++) begin
               rows            = (r < 8) ? upper : lower;
               pos_y           = longint'(cursor_line) * GLYPH_ROWS + r;
               offset          = (pos_x + pos_y * screen_width) * pixel_bytes;
               row.byte_offset = offset[OFFSET_W-1:0];
               row.pixel_mask  = rows[63 - 8 * (r % 8) -: 8];
               row.fill_color  = fg_color;
               row.last        = (r == GLYPH_ROWS - 1);
               row.off_screen  = 1'b0;
               pending.push_back(row);
            end
            glyphs_drawn++;
         end
         cursor_column = cursor_column + 1'b1;
         if (cursor_column >= columns)
            line_feed();
      endfunction

      function void check_row(logic [OFFSET_W-1:0] byte_offset, logic [7:0] pixel_mask,
                              logic [COLOR_W-1:0] fill_color, logic last, logic off_screen);
         glyph_row_type want;
         if (pending.size() == 0) begin
            $error("row write with nothing pending: byte_offset %0h", byte_offset);
            failures++;
            return;
         end
         want = pending.pop_front();
         rows_checked++;
         if (byte_offset !== want.byte_offset) begin
            $error("byte_offset: expected %0h, got %0h", want.byte_offset, byte_offset);
            failures++;
         end
         if (pixel_mask !== want.pixel_mask) begin
            $error("pixel_mask: expected %0h, got %0h", want.pixel_mask, pixel_mask);
            failures++;
         end
         if (fill_color !== want.fill_color) begin
            $error("fill_color: expected %0h, got %0h", want.fill_color, fill_color);
            failures++;
         end
         if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            failures++;
         end
         if (off_screen !== want.off_screen) begin
            $error("off_screen: expected %0b, got %0b", want.off_screen, off_screen);
            failures++;
         end
      endfunction
   endclass

   logic           clock       = 1'b0;
   logic           reset       = 1'b1;
   logic           csr_wr_en   = 1'b0;
   logic [1:0]     csr_index   = '0;
   logic [23:0]    csr_wr_data = '0;
   logic           req_tvalid  = 1'b0;
   logic           req_tready;
   logic [135:0]   req_tdata   = '0;   // char_code, glyph_upper, glyph_lower
   logic           rsp_tvalid;
   logic           rsp_tready  = 1'b0;
   logic [63:0]    rsp_tdata;          // byte_offset, pixel_mask, fill_color, zero pad
   logic           rsp_tlast;
   logic           rsp_tuser;          // off_screen

   int                  give_idle_pct = 0;
   int                  take_idle_pct = 0;
   int                  quiet_cycles  = 0;
   glyph_row_book_type  book = new();

   text_console_glyph_writer_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // row write sink with random backpressure
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         book.check_row(rsp_tdata[25:0], rsp_tdata[33:26], rsp_tdata[57:34],
                        rsp_tlast, rsp_tuser);
      rsp_tready <= ($urandom_range(0, 99) >= take_idle_pct);
   end

   // hang detection
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no transfer for %0d cycles", QUIET_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [23:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      book.write_reg(idx, value);
   endtask

   // input side is idle while registers change
   task automatic program_screen(input int unsigned width, input int unsigned height,
                                 input int unsigned pix_bytes, input int unsigned color);
      req_tvalid <= 1'b0;
      put_reg(CSR_SCREEN_WIDTH, 24'(width));
      put_reg(CSR_SCREEN_HEIGHT, 24'(height));
      put_reg(CSR_PIXEL_BYTES, 24'(pix_bytes));
      put_reg(CSR_FG_COLOR, 24'(color));
      csr_wr_en <= 1'b0;
   endtask

   // one character transfer, valid held across back-to-back items
   task automatic put_char(input logic [7:0] code, input logic [63:0] upper,
                           input logic [63:0] lower);
      while ($urandom_range(0, 99) < give_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {lower, upper, code};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      book.note_char(code, upper, lower);
   endtask

   // wait until every row write is in, then let a trailing newline finish
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (book.pending.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_chars(input int count, input int newline_pct);
      logic [7:0]  code;
      logic [63:0] upper;
      logic [63:0] lower;
      repeat (count) begin
         if ($urandom_range(0, 99) < newline_pct)
            code = NEWLINE_CODE;
         else
            code = 8'($urandom_range(0, 255));
         upper = {$urandom, $urandom};
         lower = {$urandom, $urandom};
         case ($urandom_range(0, 9))
            0: upper = '0;
            1: lower = '1;
            default: ;
         endcase
         put_char(code, upper, lower);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset geometry, sender idles a third, receiver mostly stalls
      give_idle_pct = 34;
      take_idle_pct = 70;
      put_char(8'h41, 64'hAA55AA55AA55AA55, 64'h55AA55AA55AA55AA);
      put_char(8'h00, '0, '0);
      put_char(8'hFF, '1, '1);
      put_char(NEWLINE_CODE, '1, '1);
      put_char(NEWLINE_CODE, '0, '0);
      put_char(8'h09, 64'h8040201008040201, 64'h0102040810204080);
      put_char(8'h0B, 64'hFF00FF00FF00FF00, 64'h00FF00FF00FF00FF);
      put_char(8'h0D, {$urandom, $urandom}, {$urandom, $urandom});
      put_char(8'h80, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
      put_char(8'h7F, {$urandom, $urandom}, {$urandom, $urandom});
      random_chars(40, 10);
      drain();

      // widest and tallest screen, odd pixel size
      give_idle_pct = 70;
      take_idle_pct = 34;
      program_screen(4095, 4095, 7, 0);
      random_chars(40, 10);
      drain();

      // one column, first character sees a stale column
      program_screen(8, 4095, 1, 24'hFFFFFF);
      random_chars(4, 0);
      drain();

      // narrower than one cell, zero-size pixels
      program_screen(3, 4095, 0, 24'h123456);
      random_chars(4, 0);
      drain();

      // random geometries, no idling
      give_idle_pct = 0;
      take_idle_pct = 0;
      repeat (4) begin
         program_screen($urandom_range(64, 4095), $urandom_range(2048, 4095),
                        $urandom_range(0, 7), $urandom_range(0, 24'hFFFFFF));
         random_chars(15, 10);
         drain();
      end

      // bottom line fills up, then the rest falls below the screen
      program_screen(64, (book.cursor_line + 1) * GLYPH_ROWS + $urandom_range(0, 15), 2,
                     $urandom_range(0, 24'hFFFFFF));
      put_char(NEWLINE_CODE, '0, '0);
      program_screen(64, (book.cursor_line + 1) * GLYPH_ROWS + $urandom_range(0, 15), 2,
                     $urandom_range(0, 24'hFFFFFF));
      random_chars(12, 0);
      drain();

      // single text line and no text line at all
      program_screen(800, 16, 4, 24'hABCDEF);
      random_chars(3, 0);
      drain();
      program_screen(800, 15, 3, 24'h00FF00);
      random_chars(3, 20);
      drain();

      // far down a huge screen, offsets wrap around the address space
      program_screen(4095, 4095, 7, 24'h5A5A5A);
      while (book.cursor_line < 150)
         put_char(NEWLINE_CODE, {$urandom, $urandom}, {$urandom, $urandom});
      random_chars(6, 0);
      drain();

      // dense mix of newlines and glyphs
      random_chars(20, 50);
      drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d drawn glyphs in %0d row writes, %0d suppressed, %0d newlines",
               book.glyphs_drawn, book.rows_checked, book.glyphs_hidden, book.newlines);
      $display("after %0d register writes, cursor at line %0d", book.reg_writes,
               book.cursor_line);
      if (book.failures == 0 && book.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d row writes missing", book.failures,
                  book.pending.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
